FILE: sv/pt64_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pt64_pkg: shared types and constants of the 64-bit primality tester
// Holds the sequencer state type, the trial-division primes and the
// fixed Miller-Rabin bases.
// ----------------------------------------------------------------------------
package pt64_pkg;

    localparam int unsigned NumSmallPrimes = 12;
    localparam int unsigned NumBases       = 7;

    typedef logic [63:0] t_prime_tbl [NumSmallPrimes];
    typedef logic [31:0] t_base_tbl  [NumBases];

    localparam t_prime_tbl SmallPrimes = '{
        64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd13,
        64'd17, 64'd19, 64'd23, 64'd29, 64'd31, 64'd37
    };

    localparam t_base_tbl MrBases = '{
        32'd2, 32'd325, 32'd9375, 32'd28178,
        32'd450775, 32'd9780504, 32'd1795265022
    };

    typedef enum logic [3:0] {
        S_IDLE,
        S_TD,
        S_TZ,
        S_BASE,
        S_POW,
        S_MUL,
        S_SQA,
        S_CHK,
        S_LOOP,
        S_SQX,
        S_FIN
    } t_state;

endpackage
`default_nettype wire

FILE: sv/pt64_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pt64 channel interfaces
// Valid/ready channels for the candidate beat and the result beat.
// ----------------------------------------------------------------------------
interface pt64_cand_if;
    logic        valid;
    logic        ready;
    logic [63:0] candidate;
    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

interface pt64_res_if;
    logic valid;
    logic ready;
    logic is_prime;
    modport source (output valid, output is_prime, input ready);
    modport sink   (input valid, input is_prime, output ready);
endinterface
`default_nettype wire

FILE: sv/pt64_mulmod.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pt64_mulmod: bit-serial modular multiplier
// Forms (a * b) mod m by double-and-add, one modular add per cycle,
// scanning b from its top bit. Requires a < m and m > 1.
// ----------------------------------------------------------------------------
module pt64_mulmod #(
    parameter int W  = 64,
    parameter int BW = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [W-1:0]  i_a,
    input  wire logic [BW-1:0] i_b,
    input  wire logic [W-1:0]  i_m,
    output logic               o_done,
    output logic [W-1:0]       o_result
);
    localparam int CW = (BW > 1) ? $clog2(BW) : 1;

    logic [W-1:0]  r_acc, n_acc;
    logic [W-1:0]  r_a;
    logic [BW-1:0] r_b;
    logic [W-1:0]  r_m;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_ph, n_ph;
    logic          r_run, n_run;
    logic          r_done, n_done;

    logic [W-1:0] add_y;
    logic [W-1:0] room;
    logic [W-1:0] add_sum;

    // shared modular adder: acc + y mod m
    always_comb begin
        add_y   = r_ph ? r_a : r_acc;
        room    = r_m - add_y;
        add_sum = (r_acc >= room) ? (r_acc - room) : (r_acc + add_y);
    end

    // step the double / add phases
    always_comb begin
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_ph   = r_ph;
        n_run  = r_run;
        n_done = 1'b0;
        if (r_run) begin
            n_acc = add_sum;
            if (!r_ph && r_b[r_cnt]) begin
                n_ph = 1'b1;
            end else begin
                n_ph = 1'b0;
                if (r_cnt == '0) begin
                    n_run  = 1'b0;
                    n_done = 1'b1;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
        end
        if (i_start) begin
            n_acc = '0;
            n_cnt = CW'(BW - 1);
            n_ph  = 1'b0;
            n_run = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_ph   <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_ph   <= n_ph;
        end
    end

    // operands and accumulator
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_cnt <= n_cnt;
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_m <= i_m;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule
`default_nettype wire

FILE: sv/primality_test_64bit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// primality_test_64bit: deterministic Miller-Rabin primality tester
// Trial division by 2..37, then Miller-Rabin rounds over seven fixed bases.
// ----------------------------------------------------------------------------
// One candidate beat is taken at a time and yields one is_prime beat. The
// low WORD_BITS bits of the candidate are tested. All modular arithmetic
// runs through one bit-serial modular multiplier that does one modular add
// per cycle. It scans max(WORD_BITS,32) multiplier bits, so the time a
// modular product takes grows with how many multiplier bits are set. The
// same unit handles the trial division and the base reduction. Values below
// 2 are answered without a product; a 64-bit prime needs at most about 126
// products for each of the seven bases, plus twelve trial reductions. The
// input is not ready while an item is in work; a finished result waits in
// the output register while the next candidate is taken.
module primality_test_64bit #(
    parameter int WORD_BITS = 64
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    pt64_cand_if.sink    i_cand_if,
    pt64_res_if.source   o_res_if
);
    localparam int W  = WORD_BITS;
    localparam int BW = (WORD_BITS > 32) ? WORD_BITS : 32;
    localparam int RW = $clog2(WORD_BITS);

    pt64_pkg::t_state r_state, n_state;

    logic [W-1:0]  r_n, n_n;
    logic [W-1:0]  r_d, n_d;
    logic [W-1:0]  r_e, n_e;
    logic [W-1:0]  r_a, n_a;
    logic [W-1:0]  r_x, n_x;
    logic [RW-1:0] r_r, n_r;
    logic [RW-1:0] r_i, n_i;
    logic [3:0]    r_k, n_k;
    logic          r_busy, n_busy;
    logic          r_out_valid, n_out_valid;
    logic          r_out_bit, n_out_bit;
    logic          r_res, n_res;

    logic          mm_start;
    logic [W-1:0]  mm_a;
    logic [BW-1:0] mm_b;
    logic [W-1:0]  mm_m;
    logic          mm_done;
    logic [W-1:0]  mm_res;

    logic [W-1:0]  nm1;
    logic [W-1:0]  cur_prime;
    logic          in_beat;
    logic          out_free;

    pt64_mulmod #(.W(W), .BW(BW)) u_mm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mm_start),
        .i_a     (mm_a),
        .i_b     (mm_b),
        .i_m     (mm_m),
        .o_done  (mm_done),
        .o_result(mm_res)
    );

    assign nm1       = r_n - W'(1);
    assign cur_prime = W'(pt64_pkg::SmallPrimes[r_k]);
    assign in_beat   = i_cand_if.valid && i_cand_if.ready;
    assign out_free  = !r_out_valid || o_res_if.ready;

    assign i_cand_if.ready = (r_state == pt64_pkg::S_IDLE);
    assign o_res_if.valid    = r_out_valid;
    assign o_res_if.is_prime = r_out_bit;

    // sequencer: next state and multiplier requests
    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_d         = r_d;
        n_e         = r_e;
        n_a         = r_a;
        n_x         = r_x;
        n_r         = r_r;
        n_i         = r_i;
        n_k         = r_k;
        n_busy      = r_busy;
        n_res       = r_res;
        n_out_bit   = r_out_bit;
        n_out_valid = r_out_valid && !o_res_if.ready;
        mm_start    = 1'b0;
        mm_a        = W'(1);
        mm_b        = BW'(r_n);
        mm_m        = r_n;

        case (r_state)
            pt64_pkg::S_IDLE: begin
                if (in_beat) begin
                    n_n = i_cand_if.candidate[W-1:0];
                    n_k = '0;
                    if (i_cand_if.candidate[W-1:0] < W'(2)) begin
                        n_res   = 1'b0;
                        n_state = pt64_pkg::S_FIN;
                    end else begin
                        n_state = pt64_pkg::S_TD;
                    end
                end
            end
            // n mod p for each small prime
            pt64_pkg::S_TD: begin
                mm_m = cur_prime;
                if (!r_busy) begin
                    mm_start = 1'b1;
                    n_busy   = 1'b1;
                end else if (mm_done) begin
                    n_busy = 1'b0;
                    if (mm_res == '0) begin
                        n_res   = (r_n == cur_prime);
                        n_state = pt64_pkg::S_FIN;
                    end else if (r_k == 4'(pt64_pkg::NumSmallPrimes - 1)) begin
                        n_d     = nm1;
                        n_r     = '0;
                        n_k     = '0;
                        n_state = pt64_pkg::S_TZ;
                    end else begin
                        n_k = r_k + 4'd1;
                    end
                end
            end
            // strip factors of two from n-1
            pt64_pkg::S_TZ: begin
                if (!r_d[0]) begin
                    n_d = r_d >> 1;
                    n_r = r_r + 1'b1;
                end else begin
                    n_state = pt64_pkg::S_BASE;
                end
            end
            // reduce the base mod n
            pt64_pkg::S_BASE: begin
                mm_b = BW'(pt64_pkg::MrBases[r_k[2:0]]);
                if (!r_busy) begin
                    mm_start = 1'b1;
                    n_busy   = 1'b1;
                end else if (mm_done) begin
                    n_busy = 1'b0;
                    if (mm_res == '0) begin
                        if (r_k == 4'(pt64_pkg::NumBases - 1)) begin
                            n_res   = 1'b1;
                            n_state = pt64_pkg::S_FIN;
                        end else begin
                            n_k = r_k + 4'd1;
                        end
                    end else begin
                        n_a     = mm_res;
                        n_x     = W'(1);
                        n_e     = r_d;
                        n_state = pt64_pkg::S_POW;
                    end
                end
            end
            pt64_pkg::S_POW: begin
                if (r_e == '0) begin
                    n_state = pt64_pkg::S_CHK;
                end else if (r_e[0]) begin
                    n_state = pt64_pkg::S_MUL;
                end else begin
                    n_state = pt64_pkg::S_SQA;
                end
            end
            pt64_pkg::S_MUL: begin
                mm_a = r_a;
                mm_b = BW'(r_x);
                if (!r_busy) begin
                    mm_start = 1'b1;
                    n_busy   = 1'b1;
                end else if (mm_done) begin
                    n_busy  = 1'b0;
                    n_x     = mm_res;
                    n_state = pt64_pkg::S_SQA;
                end
            end
            pt64_pkg::S_SQA: begin
                mm_a = r_a;
                mm_b = BW'(r_a);
                if (!r_busy) begin
                    mm_start = 1'b1;
                    n_busy   = 1'b1;
                end else if (mm_done) begin
                    n_busy  = 1'b0;
                    n_a     = mm_res;
                    n_e     = r_e >> 1;
                    n_state = pt64_pkg::S_POW;
                end
            end
            pt64_pkg::S_CHK: begin
                if (r_x == W'(1) || r_x == nm1) begin
                    if (r_k == 4'(pt64_pkg::NumBases - 1)) begin
                        n_res   = 1'b1;
                        n_state = pt64_pkg::S_FIN;
                    end else begin
                        n_k     = r_k + 4'd1;
                        n_state = pt64_pkg::S_BASE;
                    end
                end else begin
                    n_i     = RW'(1);
                    n_state = pt64_pkg::S_LOOP;
                end
            end
            pt64_pkg::S_LOOP: begin
                if (r_i >= r_r) begin
                    n_res   = 1'b0;
                    n_state = pt64_pkg::S_FIN;
                end else begin
                    n_state = pt64_pkg::S_SQX;
                end
            end
            pt64_pkg::S_SQX: begin
                mm_a = r_x;
                mm_b = BW'(r_x);
                if (!r_busy) begin
                    mm_start = 1'b1;
                    n_busy   = 1'b1;
                end else if (mm_done) begin
                    n_busy = 1'b0;
                    n_x    = mm_res;
                    if (mm_res == nm1) begin
                        if (r_k == 4'(pt64_pkg::NumBases - 1)) begin
                            n_res   = 1'b1;
                            n_state = pt64_pkg::S_FIN;
                        end else begin
                            n_k     = r_k + 4'd1;
                            n_state = pt64_pkg::S_BASE;
                        end
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = pt64_pkg::S_LOOP;
                    end
                end
            end
            // hand the verdict to the output register
            pt64_pkg::S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_bit   = r_res;
                    n_state     = pt64_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pt64_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pt64_pkg::S_IDLE;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    // working values
    always_ff @(posedge i_clk) begin
        r_n       <= n_n;
        r_d       <= n_d;
        r_e       <= n_e;
        r_a       <= n_a;
        r_x       <= n_x;
        r_r       <= n_r;
        r_i       <= n_i;
        r_k       <= n_k;
        r_res     <= n_res;
        r_out_bit <= n_out_bit;
    end

endmodule
`default_nettype wire

FILE: sv/pt64_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pt64_checker: port-level checks of the primality tester
// Watches the candidate and result channels and flags handshake slips.
// ----------------------------------------------------------------------------
module pt64_checker (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pt64_cand_if.sink  i_cand_if,
    pt64_res_if.source o_res_if
);
    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_if.valid && !o_res_if.ready |=>
            o_res_if.valid && $stable(o_res_if.is_prime))
        else $error("result beat dropped or changed while stalled");

    // drop ready once a candidate is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cand_if.valid && i_cand_if.ready |=> !i_cand_if.ready)
        else $error("candidate taken while still busy");

    // ready falls only on a taken candidate
    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_cand_if.ready) |-> $past(i_cand_if.valid))
        else $error("ready dropped without a candidate beat");

    // reset leaves no result pending
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_if.valid)
        else $error("result valid after reset");

endmodule

bind primality_test_64bit pt64_checker u_pt64_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_cand_if(i_cand_if),
    .o_res_if (o_res_if)
);
`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the 64-bit primality tester
// Drives candidate beats with random gaps, predicts is_prime with an
// independent Miller-Rabin model and checks every result beat in order.
// ----------------------------------------------------------------------------

class prime_scoreboard;
    bit verdicts[$];
    int errors;

    // note the predicted verdict of an accepted candidate
    function void note_candidate(bit verdict);
        verdicts.insert(verdicts.size(), verdict);
    endfunction

    // compare a result beat with the oldest pending verdict
    function void check_result(bit got);
        bit want;
        if (verdicts.size() == 0) begin
            $display("%t: unexpected result beat, expected none, actual %0d", $realtime, got);
            errors++;
        end else begin
            want = verdicts.pop_front();
            if (want != got) begin
                $display("%t: is_prime mismatch, expected %0d, actual %0d",
                         $realtime, want, got);
                errors++;
            end
        end
    endfunction
endclass

module tb;

    logic i_clk;
    logic i_rst_n;
    bit   no_idle;

    pt64_cand_if cand_if ();
    pt64_res_if  res_if ();

    prime_scoreboard verdict_board;

    primality_test_64bit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cand_if(cand_if.sink),
        .o_res_if (res_if.source)
    );

    // modular product, 128-bit intermediate
    function automatic logic [63:0] mod_mul(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        logic [127:0] p;
        p = a * b;
        return 64'(p % {64'd0, m});
    endfunction

    function automatic logic [63:0] mod_pow(logic [63:0] a, logic [63:0] e, logic [63:0] m);
        logic [63:0] acc;
        acc = 64'd1;
        while (e != 0) begin
            if (e[0]) acc = mod_mul(acc, a, m);
            a = mod_mul(a, a, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic bit is_prime_64(logic [63:0] n);
        logic [63:0] d, x, a;
        int r;
        bit witness;
        if (n < 2) return 0;
        for (int k = 0; k < pt64_pkg::NumSmallPrimes; k++)
            if (n % pt64_pkg::SmallPrimes[k] == 0) return n == pt64_pkg::SmallPrimes[k];
        d = n - 1;
        r = 0;
        while (!d[0]) begin
            d = d >> 1;
            r++;
        end
        for (int k = 0; k < pt64_pkg::NumBases; k++) begin
            a = {32'd0, pt64_pkg::MrBases[k]} % n;
            if (a == 0) continue;
            x = mod_pow(a, d, n);
            if (x == 1 || x == n - 1) continue;
            witness = 1;
            for (int i = 1; i < r; i++) begin
                x = mod_mul(x, x, n);
                if (x == n - 1) begin
                    witness = 0;
                    break;
                end
            end
            if (witness) return 0;
        end
        return 1;
    endfunction

    function automatic bit idle_now();
        return !no_idle && ($urandom_range(99) < 25);
    endfunction

    // hold one candidate beat until it is taken
    task automatic send_candidate(logic [63:0] n);
        while (idle_now()) begin
            cand_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cand_if.valid     <= 1'b1;
        cand_if.candidate <= n;
        @(posedge i_clk);
        while (!cand_if.ready) @(posedge i_clk);
        verdict_board.note_candidate(is_prime_64(n));
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // result side: random stalls, check on each accepted beat
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready)
                verdict_board.check_result(res_if.is_prime);
            res_if.ready <= !idle_now();
        end
    end

    initial begin
        logic [63:0] directed[$];
        logic [63:0] n;
        int waited;
        verdict_board     = new();
        cand_if.valid     = 1'b0;
        cand_if.candidate = 64'd0;
        i_rst_n           = 1'b0;
        no_idle           = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, small primes, bases as candidates, strong pseudoprimes
        directed = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd37, 64'd41, 64'd1369,
                     64'd325, 64'd9375, 64'd28178, 64'd450775, 64'd9780504,
                     64'd1795265022, 64'd1795265023, 64'd2047, 64'd3215031751,
                     64'd4294967291, 64'd4294967297, 64'hFFFF_FFFF_FFFF_FFC5,
                     64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                     64'h8000_0000_0000_001D, 64'd3825123056546413051,
                     64'hAAAA_AAAA_AAAA_AAAA};
        foreach (directed[i]) send_candidate(directed[i]);

        for (int i = 0; i < 75; i++) begin
            no_idle = (i >= 30 && i < 50);
            case ($urandom_range(3))
                0: n = rand64();
                1: n = rand64() | 64'd1;
                2: n = {32'd0, $urandom()} | 64'd1;
                default: n = 64'($urandom_range(200));
            endcase
            send_candidate(n);
        end
        cand_if.valid <= 1'b0;

        waited = 0;
        while (verdict_board.verdicts.size() != 0 && waited < 2000000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (100) @(posedge i_clk);
        if (verdict_board.errors == 0 && verdict_board.verdicts.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog sized for about 100 items at their slowest, taken several times over
    initial begin
        #150_000_000;
        $display("FAILURE");
        $finish;
    end
endmodule

FILE: sim.f
sv/pt64_pkg.sv
sv/pt64_if.sv
sv/pt64_mulmod.sv
sv/primality_test_64bit.sv
sv/pt64_checker.sv
test/tb.sv
